// ===== design/source_text_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer
// Concurrent checks, compiled away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked on clk, disabled while arst_n is low
`define STT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// clocked on clk, checked during reset as well
`define STT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STT_ASSERT(label, prop, msg)
`define STT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes, character constants and helpers of the source text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

	localparam int DEF_LINE_WIDTH   = 16;
	localparam int DEF_COLUMN_WIDTH = 16;
	localparam int MAX_RESULTS      = 3;
	localparam int QDEPTH           = 4;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [3:0] {
		MD_IDLE, MD_COMMENT, MD_MINUS, MD_LT, MD_GT, MD_EQ, MD_PLUS,
		MD_PLUSMINUS, MD_DOT, MD_NUMBER, MD_IDENT, MD_STRING, MD_HALT
	} mode_t;

	typedef enum logic [1:0] {
		RK_TEXT, RK_TOKEN, RK_ERROR, RK_END
	} rec_kind_t;

	typedef enum logic [4:0] {
		TK_COLON, TK_ASSIGN, TK_MINUS, TK_PARAM, TK_LE, TK_LT, TK_GE, TK_GT,
		TK_COMPARE, TK_COMMA, TK_ADDASSIGN, TK_ADD, TK_DIV, TK_MUL, TK_NUMBER,
		TK_IN, TK_PROGRAM, TK_IDENT, TK_STRING
	} tok_kind_t;

	typedef enum logic {
		EC_UNEXPECTED, EC_UNTERMINATED
	} err_code_t;

	typedef enum logic [3:0] {
		CC_SKIP, CC_HASH, CC_COLON, CC_COMMA, CC_SLASH, CC_STAR, CC_MINUS,
		CC_LT, CC_GT, CC_EQ, CC_PLUS, CC_DOT, CC_QUOTE, CC_DIGIT, CC_ALPHA,
		CC_OTHER
	} char_class_t;

	typedef struct packed {
		logic [7:0] source_char;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		rec_kind_t  record_kind;
		tok_kind_t  token_kind;
		logic [7:0] text_char;
		logic [15:0] start_line;
		logic [15:0] start_column;
		err_code_t  error_code;
		logic       last_of_item;
	} out_item_t;

	// all records caused by one transaction
	typedef struct packed {
		logic [1:0]                        count;
		out_item_t [MAX_RESULTS-1:0]       recs;
	} bundle_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		case (c)
			CH_SPACE, CH_NL: cls = CC_SKIP;
			CH_HASH:  cls = CC_HASH;
			CH_COLON: cls = CC_COLON;
			CH_COMMA: cls = CC_COMMA;
			CH_SLASH: cls = CC_SLASH;
			CH_STAR:  cls = CC_STAR;
			CH_MINUS: cls = CC_MINUS;
			CH_LT:    cls = CC_LT;
			CH_GT:    cls = CC_GT;
			CH_EQ:    cls = CC_EQ;
			CH_PLUS:  cls = CC_PLUS;
			CH_DOT:   cls = CC_DOT;
			CH_QUOTE: cls = CC_QUOTE;
			default: begin
				if (is_digit(c))
					cls = CC_DIGIT;
				else if (is_alpha(c))
					cls = CC_ALPHA;
				else
					cls = CC_OTHER;
			end
		endcase
		return cls;
	endfunction

	// "in"
	function automatic logic [7:0] kw_in_char(input logic [3:0] p);
		logic [7:0] ch;
		case (p)
			4'd0: ch = 8'h69;
			4'd1: ch = 8'h6E;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	// "program"
	function automatic logic [7:0] kw_prog_char(input logic [3:0] p);
		logic [7:0] ch;
		case (p)
			4'd0: ch = 8'h70;
			4'd1: ch = 8'h72;
			4'd2: ch = 8'h6F;
			4'd3: ch = 8'h67;
			4'd4: ch = 8'h72;
			4'd5: ch = 8'h61;
			4'd6: ch = 8'h6D;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic out_item_t mk_rec(input rec_kind_t rk, input tok_kind_t tk,
			input logic [7:0] ch, input logic [15:0] ln, input logic [15:0] cl,
			input err_code_t ec);
		out_item_t r;
		r.record_kind  = rk;
		r.token_kind   = tk;
		r.text_char    = ch;
		r.start_line   = ln;
		r.start_column = cl;
		r.error_code   = ec;
		r.last_of_item = 1'b0;
		return r;
	endfunction

endpackage

// ===== design/stt_stream_if.sv =====
// ----------------------------------------------------------------------------
// stt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stt_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: position tracking, lookahead state, record generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_front #(
	parameter int LINE_WIDTH   = stt_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = stt_pkg::DEF_COLUMN_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	stt_stream_if.sink         chars,
	output logic               push_valid,
	input  logic               push_ready,
	output stt_pkg::bundle_t   push_data
);

	localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = '1;

	stt_pkg::mode_t            mode_q, mode_d;
	logic [LINE_WIDTH-1:0]     line_q, line_d, line_adv;
	logic [COLUMN_WIDTH-1:0]   col_q, col_d, col_adv;
	logic [LINE_WIDTH-1:0]     tsl_q, tsl_d;
	logic [COLUMN_WIDTH-1:0]   tsc_q, tsc_d;
	logic [3:0]                kwp_q, kwp_d;
	logic [1:0]                kwc_q, kwc_d;

	logic [7:0]                c;
	logic                      eoi, fire, fresh, ident_cont;
	stt_pkg::char_class_t      cls;
	stt_pkg::tok_kind_t        ident_kind;
	logic [15:0]               tsl16, tsc16, ln16, cl16, lnq16, clq16, minus_col16;
	stt_pkg::out_item_t [stt_pkg::MAX_RESULTS-1:0] recs;
	logic [1:0]                n;

	assign c    = chars.data.source_char;
	assign eoi  = chars.data.end_of_input;
	assign fire = chars.valid && chars.ready;
	assign cls  = stt_pkg::classify(c);
	assign chars.ready = push_ready;

	always_comb begin
		line_adv = line_q;
		col_adv  = col_q;
		if (c == stt_pkg::CH_NL) begin
			if (line_q != LINE_MAX)
				line_adv = line_q + 1'b1;
			col_adv = '0;
		end else if (col_q != COL_MAX) begin
			col_adv = col_q + 1'b1;
		end
	end

	assign ident_cont = stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || (c == stt_pkg::CH_UNDER);

	// byte is scanned as the start of a new token
	always_comb begin
		case (mode_q)
			stt_pkg::MD_IDLE:      fresh = 1'b1;
			stt_pkg::MD_MINUS:     fresh = (c != stt_pkg::CH_GT);
			stt_pkg::MD_LT:        fresh = (c != stt_pkg::CH_MINUS) && (c != stt_pkg::CH_EQ);
			stt_pkg::MD_GT:        fresh = (c != stt_pkg::CH_EQ);
			stt_pkg::MD_PLUS:      fresh = (c != stt_pkg::CH_MINUS);
			stt_pkg::MD_PLUSMINUS: fresh = (c != stt_pkg::CH_GT);
			stt_pkg::MD_NUMBER:    fresh = !(stt_pkg::is_digit(c) || (c == stt_pkg::CH_DOT));
			stt_pkg::MD_IDENT:     fresh = !ident_cont;
			default:               fresh = 1'b0;
		endcase
	end

	always_comb begin
		if (kwc_q[0] && (kwp_q == 4'd2))
			ident_kind = stt_pkg::TK_IN;
		else if (kwc_q[1] && (kwp_q == 4'd7))
			ident_kind = stt_pkg::TK_PROGRAM;
		else
			ident_kind = stt_pkg::TK_IDENT;
	end

	assign tsl16 = 16'(tsl_q);
	assign tsc16 = 16'(tsc_q);
	assign ln16  = 16'(line_adv);
	assign cl16  = 16'(col_adv);
	assign lnq16 = 16'(line_q);
	assign clq16 = 16'(col_q);
	assign minus_col16 = (tsc_q != COL_MAX) ? 16'(tsc_q + 1'b1) : tsc16;

	// next state
	always_comb begin
		mode_d = mode_q;
		line_d = line_q;
		col_d  = col_q;
		tsl_d  = tsl_q;
		tsc_d  = tsc_q;
		kwp_d  = kwp_q;
		kwc_d  = kwc_q;
		if (fire) begin
			if (eoi) begin
				mode_d = stt_pkg::MD_IDLE;
				line_d = LINE_WIDTH'(1);
				col_d  = '0;
				tsl_d  = LINE_WIDTH'(1);
				tsc_d  = '0;
				kwp_d  = '0;
				kwc_d  = 2'b11;
			end else begin
				line_d = line_adv;
				col_d  = col_adv;
				case (mode_q)
					stt_pkg::MD_COMMENT:
						if (c == stt_pkg::CH_NL) mode_d = stt_pkg::MD_IDLE;
					stt_pkg::MD_MINUS, stt_pkg::MD_GT, stt_pkg::MD_LT,
					stt_pkg::MD_PLUSMINUS:
						mode_d = stt_pkg::MD_IDLE;
					stt_pkg::MD_EQ:
						mode_d = (c == stt_pkg::CH_QMARK) ? stt_pkg::MD_IDLE : stt_pkg::MD_HALT;
					stt_pkg::MD_PLUS:
						mode_d = stt_pkg::MD_PLUSMINUS;
					stt_pkg::MD_DOT:
						mode_d = stt_pkg::is_digit(c) ? stt_pkg::MD_NUMBER : stt_pkg::MD_HALT;
					stt_pkg::MD_IDENT: begin
						if (ident_cont) begin
							if (!((kwp_q < 4'd2) && (stt_pkg::kw_in_char(kwp_q) == c)))
								kwc_d[0] = 1'b0;
							if (!((kwp_q < 4'd7) && (stt_pkg::kw_prog_char(kwp_q) == c)))
								kwc_d[1] = 1'b0;
							if (kwp_q != 4'd15)
								kwp_d = kwp_q + 4'd1;
						end
					end
					stt_pkg::MD_STRING:
						if (c == stt_pkg::CH_QUOTE) mode_d = stt_pkg::MD_IDLE;
					default: ;
				endcase
				if (fresh) begin
					case (cls)
						stt_pkg::CC_HASH:  mode_d = stt_pkg::MD_COMMENT;
						stt_pkg::CC_MINUS: mode_d = stt_pkg::MD_MINUS;
						stt_pkg::CC_LT:    mode_d = stt_pkg::MD_LT;
						stt_pkg::CC_GT:    mode_d = stt_pkg::MD_GT;
						stt_pkg::CC_EQ:    mode_d = stt_pkg::MD_EQ;
						stt_pkg::CC_PLUS:  mode_d = stt_pkg::MD_PLUS;
						stt_pkg::CC_DOT:   mode_d = stt_pkg::MD_DOT;
						stt_pkg::CC_QUOTE: mode_d = stt_pkg::MD_STRING;
						stt_pkg::CC_DIGIT: mode_d = stt_pkg::MD_NUMBER;
						stt_pkg::CC_ALPHA: mode_d = stt_pkg::MD_IDENT;
						stt_pkg::CC_OTHER: mode_d = stt_pkg::MD_HALT;
						default:           mode_d = stt_pkg::MD_IDLE;
					endcase
					if ((cls != stt_pkg::CC_SKIP) && (cls != stt_pkg::CC_HASH) &&
					    (cls != stt_pkg::CC_OTHER)) begin
						tsl_d = line_adv;
						tsc_d = col_adv;
					end
					if (cls == stt_pkg::CC_ALPHA) begin
						kwp_d = 4'd1;
						kwc_d = {c == stt_pkg::kw_prog_char(4'd0), c == stt_pkg::kw_in_char(4'd0)};
					end
				end
			end
		end
	end

	// records of this transaction
	always_comb begin
		recs = '0;
		n    = '0;
		if (eoi) begin
			case (mode_q)
				stt_pkg::MD_MINUS, stt_pkg::MD_LT, stt_pkg::MD_GT, stt_pkg::MD_PLUS,
				stt_pkg::MD_PLUSMINUS, stt_pkg::MD_NUMBER, stt_pkg::MD_IDENT: begin
					case (mode_q)
						stt_pkg::MD_MINUS:  recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							stt_pkg::TK_MINUS, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						stt_pkg::MD_LT:     recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							stt_pkg::TK_LT, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						stt_pkg::MD_GT:     recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							stt_pkg::TK_GT, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						stt_pkg::MD_NUMBER: recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							stt_pkg::TK_NUMBER, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						stt_pkg::MD_IDENT:  recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							ident_kind, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						default:            recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							stt_pkg::TK_ADD, stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					endcase
					n = n + 2'd1;
					if (mode_q == stt_pkg::MD_PLUSMINUS) begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_MINUS,
							stt_pkg::CH_NUL, tsl16, minus_col16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
				end
				stt_pkg::MD_EQ, stt_pkg::MD_DOT: begin
					recs[n] = stt_pkg::mk_rec(stt_pkg::RK_ERROR, stt_pkg::TK_COLON,
						(mode_q == stt_pkg::MD_EQ) ? stt_pkg::CH_EQ : stt_pkg::CH_DOT,
						tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_STRING: begin
					recs[n] = stt_pkg::mk_rec(stt_pkg::RK_ERROR, stt_pkg::TK_COLON,
						stt_pkg::CH_NUL, lnq16, clq16, stt_pkg::EC_UNTERMINATED);
					n = n + 2'd1;
				end
				default: ;
			endcase
			recs[n] = stt_pkg::mk_rec(stt_pkg::RK_END, stt_pkg::TK_COLON, stt_pkg::CH_NUL,
				lnq16, clq16, stt_pkg::EC_UNEXPECTED);
			n = n + 2'd1;
		end else begin
			// close or extend the pending token
			case (mode_q)
				stt_pkg::MD_MINUS: begin
					recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
						(c == stt_pkg::CH_GT) ? stt_pkg::TK_ASSIGN : stt_pkg::TK_MINUS,
						stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_LT: begin
					recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
						(c == stt_pkg::CH_MINUS) ? stt_pkg::TK_PARAM :
						(c == stt_pkg::CH_EQ) ? stt_pkg::TK_LE : stt_pkg::TK_LT,
						stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_GT: begin
					recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
						(c == stt_pkg::CH_EQ) ? stt_pkg::TK_GE : stt_pkg::TK_GT,
						stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_EQ: begin
					if (c == stt_pkg::CH_QMARK)
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_COMPARE,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					else
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_ERROR, stt_pkg::TK_COLON,
							stt_pkg::CH_EQ, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_PLUS: begin
					if (c != stt_pkg::CH_MINUS) begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_ADD,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
				end
				stt_pkg::MD_PLUSMINUS: begin
					if (c == stt_pkg::CH_GT) begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_ADDASSIGN,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end else begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_ADD,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_MINUS,
							stt_pkg::CH_NUL, tsl16, minus_col16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
				end
				stt_pkg::MD_DOT: begin
					if (stt_pkg::is_digit(c)) begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT, stt_pkg::TK_NUMBER,
							stt_pkg::CH_DOT, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT, stt_pkg::TK_NUMBER,
							c, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end else begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_ERROR, stt_pkg::TK_COLON,
							stt_pkg::CH_DOT, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
				end
				stt_pkg::MD_NUMBER: begin
					if (fresh)
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_NUMBER,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					else
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT, stt_pkg::TK_NUMBER,
							c, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_IDENT: begin
					if (fresh)
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, ident_kind,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					else
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT, stt_pkg::TK_IDENT,
							c, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				stt_pkg::MD_STRING: begin
					if (c == stt_pkg::CH_QUOTE)
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN, stt_pkg::TK_STRING,
							stt_pkg::CH_NUL, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					else
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT, stt_pkg::TK_STRING,
							c, tsl16, tsc16, stt_pkg::EC_UNEXPECTED);
					n = n + 2'd1;
				end
				default: ;
			endcase
			// byte opens a new token; start is the advanced position
			if (fresh) begin
				case (cls)
					stt_pkg::CC_COLON, stt_pkg::CC_COMMA, stt_pkg::CC_SLASH,
					stt_pkg::CC_STAR: begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TOKEN,
							(cls == stt_pkg::CC_COLON) ? stt_pkg::TK_COLON :
							(cls == stt_pkg::CC_COMMA) ? stt_pkg::TK_COMMA :
							(cls == stt_pkg::CC_SLASH) ? stt_pkg::TK_DIV : stt_pkg::TK_MUL,
							stt_pkg::CH_NUL, ln16, cl16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
					stt_pkg::CC_DIGIT, stt_pkg::CC_ALPHA: begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_TEXT,
							(cls == stt_pkg::CC_DIGIT) ? stt_pkg::TK_NUMBER : stt_pkg::TK_IDENT,
							c, ln16, cl16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
					stt_pkg::CC_OTHER: begin
						recs[n] = stt_pkg::mk_rec(stt_pkg::RK_ERROR, stt_pkg::TK_COLON,
							c, ln16, cl16, stt_pkg::EC_UNEXPECTED);
						n = n + 2'd1;
					end
					default: ;
				endcase
			end
		end
	end

	assign push_valid     = fire && (n != 2'd0);
	assign push_data.count = n;
	assign push_data.recs  = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MD_IDLE;
			line_q <= LINE_WIDTH'(1);
			col_q  <= '0;
			tsl_q  <= LINE_WIDTH'(1);
			tsc_q  <= '0;
			kwp_q  <= '0;
			kwc_q  <= 2'b11;
		end else begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			tsl_q  <= tsl_d;
			tsc_q  <= tsc_d;
			kwp_q  <= kwp_d;
			kwc_q  <= kwc_d;
		end
	end

endmodule

// ===== design/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short register FIFO of record bundles between scanner and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "source_text_tokenizer_defines.svh"

module stt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  stt_pkg::bundle_t push_data,
	output logic             pop_valid,
	input  logic             pop,
	output stt_pkg::bundle_t head
);

	localparam int AW = $clog2(stt_pkg::QDEPTH);
	localparam int CW = $clog2(stt_pkg::QDEPTH + 1);

	stt_pkg::bundle_t mem_q [stt_pkg::QDEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             push_fire, pop_fire;

	assign push_ready = (count_q != CW'(stt_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop && pop_valid;
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_fire)
				wptr_q <= (wptr_q == AW'(stt_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop_fire)
				rptr_q <= (rptr_q == AW'(stt_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + CW'(push_fire) - CW'(pop_fire);
		end
	end

	`STT_ASSERT(a_count_bound, count_q <= CW'(stt_pkg::QDEPTH), "queue count above depth")
	`STT_ASSERT(a_no_push_full, push_valid |-> push_ready, "push offered while queue full")
	`STT_ASSERT(a_count_track, $past(arst_n) |-> (count_q == CW'($past(count_q) + CW'($past(push_fire)) - CW'($past(pop_fire)))), "queue count out of step")

endmodule

// ===== design/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Output stage: plays out the records of each bundle, one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "source_text_tokenizer_defines.svh"

module stt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  stt_pkg::bundle_t head,
	output logic             pop,
	stt_stream_if.source     records
);

	logic [1:0] idx_q;
	logic       last;
	logic       fire;

	assign last  = (idx_q == (head.count - 2'd1));
	assign fire  = records.valid && records.ready;
	assign pop   = fire && last;

	assign records.valid = pop_valid;
	always_comb begin
		records.data              = head.recs[idx_q];
		records.data.last_of_item = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	`STT_ASSERT(a_idx_in_bundle, pop_valid |-> ((head.count != 2'd0) && (idx_q < head.count)), "record index outside bundle")
	`STT_ASSERT_ALWAYS(a_idx_idle, (!arst_n || pop_valid) || (idx_q == 2'd0), "record index nonzero with queue empty")

endmodule

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one source byte per transaction in, token records out.
// ----------------------------------------------------------------------------
// Each input transaction carries one source byte or an end-of-input mark. The
// block tracks line and column (saturating), skips spaces, newlines and '#'
// comments, resolves multi-character operators with up to two bytes of
// lookahead, and emits records: text characters of numbers, identifiers and
// strings, token-complete records with start line/column, errors, and an end
// record. A byte causes zero to three records; the last carries last_of_item.
// After an error the scanner ignores bytes until end of input; end of input
// restores the reset state for the next source.
// Timing: the scanner takes one byte every cycle while its queue has room,
// and its records pass through the registered bundle queue to the output.
// The output port drains one record per cycle while the receiver is ready, so
// sustained throughput is one byte per cycle when each byte gives at most one
// record, and a byte that gives several records holds the output until all of
// them are played out. A four-entry bundle queue between scanner and output
// stage absorbs output stalls and bursts of multi-record bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer #(
	parameter int LINE_WIDTH   = stt_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = stt_pkg::DEF_COLUMN_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	stt_stream_if.sink   chars,     // payload stt_pkg::in_item_t
	stt_stream_if.source records    // payload stt_pkg::out_item_t
);

	// front to queue
	logic             push_valid;
	logic             push_ready;
	stt_pkg::bundle_t push_data;

	// queue to back
	logic             pop_valid;
	logic             pop;
	stt_pkg::bundle_t head;

	// scanner: classifies each byte, updates mode and position, builds the
	// bundle of records it causes
	stt_front #(
		.LINE_WIDTH   (LINE_WIDTH),
		.COLUMN_WIDTH (COLUMN_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples scanner from output backpressure
	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.head       (head)
	);

	// serializes each bundle onto the record channel
	stt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.head      (head),
		.pop       (pop),
		.records   (records)
	);

endmodule
